[hdl/plc_pkg.sv]
// Shared types and constants of the parcel locker controller.
`timescale 1ns / 1ps

package plc_pkg;

  localparam int DIST_W     = 10;
  localparam int WEIGHT_W   = 32;
  localparam int THRESH_W   = 24;
  localparam int LEVEL_W    = 4;
  localparam int TICK_W     = 16;
  localparam int PHASE_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [DIST_W-1:0]   DETECT_RST   = 10'd15;
  localparam logic [THRESH_W-1:0] THRESH_RST   = 24'd200000;
  localparam logic [LEVEL_W-1:0]  CONFIRM_RST  = 4'd3;
  localparam logic [LEVEL_W-1:0]  MAXFAIL_RST  = 4'd5;
  localparam logic [TICK_W-1:0]   HOLD_RST     = 16'd30;
  localparam logic [TICK_W-1:0]   SETTLE_RST   = 16'd8;
  localparam logic [TICK_W-1:0]   COOLDOWN_RST = 16'd20;
  localparam logic [LEVEL_W-1:0]  LEVEL_MAX    = 4'd15;
  localparam logic [TICK_W-1:0]   TICK_MAX     = 16'hFFFF;

  typedef enum logic [PHASE_W-1:0] {
    PH_SAMPLING = 3'd0,
    PH_IDLE     = 3'd1,
    PH_ACTING   = 3'd2,
    PH_SETTLING = 3'd3,
    PH_ERROR    = 3'd4
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DETECT   = 3'd0,
    CFG_THRESH   = 3'd1,
    CFG_CONFIRM  = 3'd2,
    CFG_MAXFAIL  = 3'd3,
    CFG_HOLD     = 3'd4,
    CFG_SETTLE   = 3'd5,
    CFG_COOLDOWN = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_WAIT,
    ST_EVAL,
    ST_DIV,
    ST_PUSH
  } ctrl_state_e;

  typedef struct packed {
    logic in_load;
    logic eval;
    logic div_start;
    logic base_load;
    logic out_load;
  } plc_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_busy;
  } plc_sts_t;

endpackage

[hdl/plc_div.sv]
// Signed by unsigned restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module plc_div #(
  parameter int NUM_W = 35,
  parameter int DEN_W = 3
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic        [DEN_W-1:0] den_i,
  output logic                    busy_o,
  output logic signed [NUM_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             neg_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;
  logic [NUM_W-1:0] mag;

  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};
  assign mag   = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= mag;
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= num_i[NUM_W-1];
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], fits};
      rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

[hdl/plc_dp.sv]
// Datapath: configuration, input capture, tick state, next-state logic, baseline divider and result register.
`timescale 1ns / 1ps

module plc_dp #(
  parameter int BASELINE_COUNT = 5
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  plc_pkg::plc_cmd_t              cmd_i,
  output plc_pkg::plc_sts_t              sts_o,
  input  logic                           distance_valid_i,
  input  logic [plc_pkg::DIST_W-1:0]     distance_cm_i,
  input  logic                           weight_valid_i,
  input  logic signed [plc_pkg::WEIGHT_W-1:0] weight_mg_i,
  input  logic                           move_failed_i,
  input  logic                           cfg_we_i,
  input  logic [plc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [plc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic [plc_pkg::PHASE_W-1:0]    phase_o,
  output logic                           open_command_o,
  output logic                           close_command_o,
  output logic                           near_flag_o,
  output logic                           heavy_flag_o,
  output logic [plc_pkg::LEVEL_W-1:0]    confirm_level_o,
  output logic [plc_pkg::LEVEL_W-1:0]    failure_level_o,
  output logic signed [plc_pkg::WEIGHT_W-1:0] baseline_out_o
);

  import plc_pkg::*;

  localparam int CNT_W = $clog2(BASELINE_COUNT + 1);
  localparam int SUM_W = WEIGHT_W + CNT_W;

  // Configuration registers.
  logic [DIST_W-1:0]   det_q;
  logic [THRESH_W-1:0] thr_q;
  logic [LEVEL_W-1:0]  confirm_q;
  logic [LEVEL_W-1:0]  maxfail_q;
  logic [TICK_W-1:0]   hold_q;
  logic [TICK_W-1:0]   settle_q;
  logic [TICK_W-1:0]   cool_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_q     <= DETECT_RST;
      thr_q     <= THRESH_RST;
      confirm_q <= CONFIRM_RST;
      maxfail_q <= MAXFAIL_RST;
      hold_q    <= HOLD_RST;
      settle_q  <= SETTLE_RST;
      cool_q    <= COOLDOWN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DETECT:   det_q     <= cfg_data_i[DIST_W-1:0];
        CFG_THRESH:   thr_q     <= cfg_data_i[THRESH_W-1:0];
        CFG_CONFIRM:  confirm_q <= cfg_data_i[LEVEL_W-1:0];
        CFG_MAXFAIL:  maxfail_q <= cfg_data_i[LEVEL_W-1:0];
        CFG_HOLD:     hold_q    <= cfg_data_i[TICK_W-1:0];
        CFG_SETTLE:   settle_q  <= cfg_data_i[TICK_W-1:0];
        CFG_COOLDOWN: cool_q    <= cfg_data_i[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured tick readings.
  logic                       dv_q;
  logic [DIST_W-1:0]          cm_q;
  logic                       wv_q;
  logic signed [WEIGHT_W-1:0] mg_q;
  logic                       mf_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      dv_q <= distance_valid_i;
      cm_q <= distance_cm_i;
      wv_q <= weight_valid_i;
      mg_q <= weight_mg_i;
      mf_q <= move_failed_i;
    end
  end

  // Tick state.
  phase_e                     phase_q, phase_d;
  logic [TICK_W-1:0]          el_q, el_d;
  logic [LEVEL_W-1:0]         cc_q, cc_d;
  logic [LEVEL_W-1:0]         fc_q, fc_d;
  logic signed [WEIGHT_W-1:0] base_q;
  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic [CNT_W-1:0]           vs_q, vs_d;
  logic [CNT_W-1:0]           idx_q, idx_d;
  logic                       init_q, init_d;
  logic                       open_q, open_d;
  logic                       close_q, close_d;
  logic                       near_q, near_d;
  logic                       heavy_q, heavy_d;
  logic                       entered;
  logic                       need_div;

  logic [TICK_W-1:0]          el_inc;
  logic [LEVEL_W-1:0]         fc_inc;
  logic [LEVEL_W-1:0]         cc_inc;
  logic signed [SUM_W-1:0]    sum_add;
  logic [CNT_W-1:0]           vs_inc;
  logic [CNT_W-1:0]           idx_inc;
  logic signed [WEIGHT_W:0]   rise;
  logic signed [WEIGHT_W:0]   thr_ext;
  logic                       near_c;
  logic                       heavy_c;
  phase_e                     settle_ph;
  logic signed [SUM_W-1:0]    quo;
  logic                       div_busy;

  assign el_inc  = (el_q == TICK_MAX) ? el_q : el_q + 1'b1;
  assign fc_inc  = (fc_q == LEVEL_MAX) ? fc_q : fc_q + 1'b1;
  assign cc_inc  = (cc_q == LEVEL_MAX) ? cc_q : cc_q + 1'b1;
  assign sum_add = wv_q ? sum_q + SUM_W'(mg_q) : sum_q;
  assign vs_inc  = vs_q + CNT_W'(wv_q);
  assign idx_inc = idx_q + 1'b1;
  assign rise    = $signed({mg_q[WEIGHT_W-1], mg_q}) - $signed({base_q[WEIGHT_W-1], base_q});
  assign thr_ext = $signed({{(WEIGHT_W + 1 - THRESH_W){1'b0}}, thr_q});
  assign near_c  = (cm_q != '0) && (cm_q < det_q);
  assign heavy_c = rise > thr_ext;
  assign settle_ph = (settle_q == '0) ? PH_SAMPLING : PH_SETTLING;

  always_comb begin
    phase_d  = phase_q;
    el_d     = el_q;
    cc_d     = cc_q;
    fc_d     = fc_q;
    sum_d    = sum_q;
    vs_d     = vs_q;
    idx_d    = idx_q;
    init_d   = init_q;
    open_d   = 1'b0;
    close_d  = 1'b0;
    near_d   = 1'b0;
    heavy_d  = 1'b0;
    entered  = 1'b0;
    need_div = 1'b0;
    case (phase_q)
      PH_SAMPLING: begin
        sum_d = sum_add;
        vs_d  = vs_inc;
        idx_d = idx_inc;
        if (idx_inc >= CNT_W'(BASELINE_COUNT)) begin
          need_div = (vs_inc != '0);
          phase_d  = ((vs_inc == '0) && init_q) ? PH_ERROR : PH_IDLE;
          entered  = 1'b1;
          init_d   = 1'b0;
        end
      end
      PH_IDLE: begin
        if (!dv_q || !wv_q) begin
          fc_d = fc_inc;
          if (fc_inc >= maxfail_q) begin
            phase_d = PH_ERROR;
            entered = 1'b1;
          end
        end else begin
          fc_d    = '0;
          near_d  = near_c;
          heavy_d = heavy_c;
          cc_d    = (near_c && heavy_c) ? cc_inc : '0;
          if (cc_d >= confirm_q) begin
            cc_d    = '0;
            open_d  = 1'b1;
            phase_d = mf_q ? PH_ERROR : PH_ACTING;
            entered = 1'b1;
          end
        end
      end
      PH_ACTING: begin
        el_d = el_inc;
        if (el_inc >= hold_q) begin
          close_d = 1'b1;
          phase_d = mf_q ? PH_ERROR : settle_ph;
          entered = 1'b1;
        end
      end
      PH_SETTLING: begin
        el_d = el_inc;
        if (el_inc >= settle_q) begin
          phase_d = PH_SAMPLING;
          entered = 1'b1;
        end
      end
      default: begin
        // Error, and any phase code that means nothing.
        phase_d = PH_ERROR;
        el_d    = el_inc;
        if (el_inc > cool_q) begin
          fc_d    = '0;
          cc_d    = '0;
          close_d = 1'b1;
          phase_d = settle_ph;
          entered = 1'b1;
        end
      end
    endcase
    if (entered) begin
      el_d = '0;
      if (phase_d == PH_SAMPLING) begin
        sum_d = '0;
        vs_d  = '0;
        idx_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SAMPLING;
      el_q    <= '0;
      cc_q    <= '0;
      fc_q    <= '0;
      base_q  <= '0;
      sum_q   <= '0;
      vs_q    <= '0;
      idx_q   <= '0;
      init_q  <= 1'b1;
      open_q  <= 1'b0;
      close_q <= 1'b0;
      near_q  <= 1'b0;
      heavy_q <= 1'b0;
    end else begin
      if (cmd_i.eval) begin
        phase_q <= phase_d;
        el_q    <= el_d;
        cc_q    <= cc_d;
        fc_q    <= fc_d;
        sum_q   <= sum_d;
        vs_q    <= vs_d;
        idx_q   <= idx_d;
        init_q  <= init_d;
        open_q  <= open_d;
        close_q <= close_d;
        near_q  <= near_d;
        heavy_q <= heavy_d;
      end
      if (cmd_i.base_load) begin
        base_q <= quo[WEIGHT_W-1:0];
      end
    end
  end

  // The new baseline is the sample sum over the valid-sample count.
  plc_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (sum_add),
    .den_i   (vs_inc),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  assign sts_o.need_div = need_div;
  assign sts_o.div_busy = div_busy;

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      phase_o         <= phase_q;
      open_command_o  <= open_q;
      close_command_o <= close_q;
      near_flag_o     <= near_q;
      heavy_flag_o    <= heavy_q;
      confirm_level_o <= cc_q;
      failure_level_o <= fc_q;
      baseline_out_o  <= base_q;
    end
  end

endmodule

[hdl/plc_ctrl.sv]
// Controller: sequences one tick through evaluate, divide and result hand-off.
`timescale 1ns / 1ps

module plc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  input  plc_pkg::plc_sts_t sts_i,
  output plc_pkg::plc_cmd_t cmd_o
);

  import plc_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_WAIT: if (in_valid_i) state_d = ST_EVAL;
      ST_EVAL: state_d = sts_i.need_div ? ST_DIV : ST_PUSH;
      ST_DIV:  if (!sts_i.div_busy) state_d = ST_PUSH;
      ST_PUSH: if (out_free) state_d = ST_WAIT;
      default: state_d = ST_WAIT;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_WAIT: cmd_o.in_load = in_valid_i;
      ST_EVAL: begin
        cmd_o.eval      = 1'b1;
        cmd_o.div_start = sts_i.need_div;
      end
      ST_DIV:  cmd_o.base_load = !sts_i.div_busy;
      ST_PUSH: cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_WAIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_WAIT);
  assign out_valid_o = out_valid_q;

endmodule

[hdl/parcel_locker_controller.sv]
// Top level of the parcel locker controller.
`timescale 1ns / 1ps

// Each input transaction is one tick: distance and weight readings with
// their valid flags, plus a flag saying the servo move commanded on this
// tick failed. Each tick yields exactly one result transaction that shows
// the phase after the tick, the open and close command pulses, the near and
// heavy flags, both counters and the current weight baseline.
// Both data channels move a transaction on a clock edge where valid is high
// and stall is low. Configuration writes use their own valid/ready channel,
// are always ready, and must only be issued while no tick is in flight.
// An ordinary tick runs capture at the accepting edge, then evaluate, then
// the load of the result register. Input stays stalled until the tick is
// done, so a new tick is not accepted before the last one is through. The
// tick that closes a baseline pass with at least one valid sample also runs
// the baseline division, one quotient bit per cycle over the sample sum.
// The result register separates the channels: a new tick is accepted while
// an earlier result still waits, and if the receiver keeps stalling, the
// following result waits in the evaluate path and input stays stalled.
// Reset restores the configuration and tick state and starts the initial
// baseline pass; no item is lost or repeated across a receiver stall.

module parcel_locker_controller #(
  parameter int BASELINE_COUNT = 5
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                distance_valid_i,
  input  logic [plc_pkg::DIST_W-1:0]          distance_cm_i,
  input  logic                                weight_valid_i,
  input  logic signed [plc_pkg::WEIGHT_W-1:0] weight_mg_i,
  input  logic                                move_failed_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [plc_pkg::PHASE_W-1:0]         phase_o,
  output logic                                open_command_o,
  output logic                                close_command_o,
  output logic                                near_flag_o,
  output logic                                heavy_flag_o,
  output logic [plc_pkg::LEVEL_W-1:0]         confirm_level_o,
  output logic [plc_pkg::LEVEL_W-1:0]         failure_level_o,
  output logic signed [plc_pkg::WEIGHT_W-1:0] baseline_out_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [plc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [plc_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  import plc_pkg::*;

  plc_cmd_t cmd;
  plc_sts_t sts;

  // Configuration writes go straight into their registers, so the port never waits.
  assign cfg_ready_o = 1'b1;

  plc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  plc_dp #(
    .BASELINE_COUNT (BASELINE_COUNT)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .distance_valid_i (distance_valid_i),
    .distance_cm_i    (distance_cm_i),
    .weight_valid_i   (weight_valid_i),
    .weight_mg_i      (weight_mg_i),
    .move_failed_i    (move_failed_i),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .phase_o          (phase_o),
    .open_command_o   (open_command_o),
    .close_command_o  (close_command_o),
    .near_flag_o      (near_flag_o),
    .heavy_flag_o     (heavy_flag_o),
    .confirm_level_o  (confirm_level_o),
    .failure_level_o  (failure_level_o),
    .baseline_out_o   (baseline_out_o)
  );

endmodule

[hdl/plc_checker.sv]
// Port-level checker of the parcel locker controller and its bind.
`timescale 1ns / 1ps

module plc_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [plc_pkg::PHASE_W-1:0]         phase_o,
  input logic                                open_command_o,
  input logic                                close_command_o
);

  import plc_pkg::*;

  // A result waiting on a stalled receiver stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Ticks are handled one at a time: the cycle after a transaction is busy.
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted on consecutive cycles");

  a_no_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(open_command_o && close_command_o))
    else $error("open and close commanded on the same tick");

  // Opening leads to acting, or to error when the move failed.
  a_open_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && open_command_o |->
      (phase_o == PH_ACTING) || (phase_o == PH_ERROR))
    else $error("open command with an unexpected phase");

  // Closing leads to settling, sampling, or error when the move failed.
  a_close_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && close_command_o |->
      (phase_o == PH_SETTLING) || (phase_o == PH_SAMPLING) || (phase_o == PH_ERROR))
    else $error("close command with an unexpected phase");

endmodule

bind parcel_locker_controller plc_checker u_plc_checker (.*);
